// ===== rtl/bsr_pkg.sv =====
// ============================================================================
// bsr_pkg - byte stream reassembler shared definitions
// Field widths, reset values and the shared position adder interface.
// ============================================================================
package bsr_pkg;

    localparam int POS_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int CFG_W          = 6;
    localparam int PEND_W         = 6;
    localparam int WINDOW_DEFAULT = 32;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 6'd32;

    typedef enum logic [0:0] {
        ALU_INC = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [POS_W-1:0] value;
        logic             carry;
    } alu_res_t;

endpackage

// ===== rtl/bsr_pos_alu.sv =====
// ============================================================================
// bsr_pos_alu - shared 32-bit position adder
// One carry chain: a - b (carry set when a >= b) or a + 1.
// ============================================================================
module bsr_pos_alu (
    input  bsr_pkg::alu_op_t               op,
    input  logic [bsr_pkg::POS_W-1:0]      a,
    input  logic [bsr_pkg::POS_W-1:0]      b,
    output bsr_pkg::alu_res_t              res
);

    logic [bsr_pkg::POS_W-1:0] b_term;
    logic [bsr_pkg::POS_W:0]   sum;

    // subtract as a + ~b + 1, increment as a + 0 + 1
    assign b_term = (op == bsr_pkg::ALU_SUB) ? ~b : '0;
    assign sum    = {1'b0, a} + {1'b0, b_term} + {{bsr_pkg::POS_W{1'b0}}, 1'b1};

    assign res.value = sum[bsr_pkg::POS_W-1:0];
    assign res.carry = sum[bsr_pkg::POS_W];

endmodule

// ===== rtl/byte_stream_reassembler_unit.sv =====
// ============================================================================
// byte_stream_reassembler_unit - sliding window byte reassembler
// Holds out-of-order bytes in a ring and emits the in-order run behind them.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | stream_position, data_byte, final_byte
//  out     | out_valid / out_stall| assembled_byte, last_of_run, stream_ended,
//          |                      | acknowledged_position, pending_bytes
//  cfg     | cfg_valid / cfg_ready| window_size
//
//  A dropped or stored byte passes the idle and calc steps; an in-order byte
//  also the first-emit step, and each held byte drained behind it a registered
//  ring read, then output load. All position math uses one shared 32-bit adder.
//  Reset clears the valid marks at once; there is no clearing pass.
//  A stalled output holds the sequencer at its emit step.
// ============================================================================
module byte_stream_reassembler_unit #(
    parameter int WINDOW = bsr_pkg::WINDOW_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bsr_pkg::POS_W-1:0]    stream_position,
    input  logic [bsr_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         final_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bsr_pkg::BYTE_W-1:0]   assembled_byte,
    output logic                         last_of_run,
    output logic                         stream_ended,
    output logic [bsr_pkg::POS_W-1:0]    acknowledged_position,
    output logic [bsr_pkg::PEND_W-1:0]   pending_bytes,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bsr_pkg::CFG_W-1:0]    window_size
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int CMP_W  = (CNT_W > bsr_pkg::CFG_W) ? CNT_W : bsr_pkg::CFG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    // control state
    logic [2:0]                    state_reg, state_next;
    logic [bsr_pkg::POS_W-1:0]     expect_reg, expect_next;
    logic                          end_known_reg, end_known_next;
    logic [bsr_pkg::POS_W-1:0]     end_pos_reg, end_pos_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [SLOT_W-1:0]             head_reg, head_next;
    logic [WINDOW-1:0]             held_valid_reg, held_valid_next;
    logic [bsr_pkg::CFG_W-1:0]     win_size_reg;
    logic                          out_valid_reg, out_valid_next;

    // item and output payload
    logic [bsr_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [bsr_pkg::BYTE_W-1:0]    byte_reg, byte_next;
    logic [bsr_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;
    logic                          out_ended_reg;
    logic [bsr_pkg::POS_W-1:0]     out_ack_reg;
    logic [bsr_pkg::PEND_W-1:0]    out_pend_reg;

    // ring storage
    logic [bsr_pkg::BYTE_W-1:0]    held_bytes [WINDOW];
    logic [bsr_pkg::BYTE_W-1:0]    rd_data_reg;
    logic                          mem_wr_en;

    // shared adder
    bsr_pkg::alu_op_t              alu_op;
    logic [bsr_pkg::POS_W-1:0]     alu_a;
    logic [bsr_pkg::POS_W-1:0]     alu_b;
    bsr_pkg::alu_res_t             alu_res;

    logic                          out_free;
    logic                          load_out;
    logic [CMP_W-1:0]              win_ext;
    logic [CMP_W-1:0]              win_eff;
    logic                          too_far;
    logic [SLOT_W:0]               slot_sum;
    logic [SLOT_W-1:0]             slot;
    logic [SLOT_W-1:0]             head_inc;

    bsr_pos_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    always_comb
    begin
        alu_op = bsr_pkg::ALU_INC;
        alu_a  = expect_reg;
        alu_b  = expect_reg;
        if (state_reg == S_IDLE)
        begin
            alu_a = stream_position;
        end
        else if (state_reg == S_CALC)
        begin
            alu_op = bsr_pkg::ALU_SUB;
            alu_a  = pos_reg;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign win_ext = CMP_W'(win_size_reg);
    assign win_eff = (win_ext > CMP_W'(WINDOW)) ? CMP_W'(WINDOW) : win_ext;
    assign too_far = (|alu_res.value[bsr_pkg::POS_W-1:CMP_W]) ||
                     (alu_res.value[CMP_W-1:0] >= win_eff);

    assign slot_sum = {1'b0, head_reg} + {1'b0, alu_res.value[SLOT_W-1:0]};
    assign slot     = (slot_sum >= (SLOT_W+1)'(WINDOW))
                      ? SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW))
                      : slot_sum[SLOT_W-1:0];
    assign head_inc = (head_reg == SLOT_W'(WINDOW - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        expect_next     = expect_reg;
        end_known_next  = end_known_reg;
        end_pos_next    = end_pos_reg;
        cnt_next        = cnt_reg;
        head_next       = head_reg;
        held_valid_next = held_valid_reg;
        pos_next        = pos_reg;
        byte_next       = byte_reg;
        mem_wr_en       = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next  = stream_position;
                    byte_next = data_byte;
                    if (final_byte)
                    begin
                        end_known_next = 1'b1;
                        end_pos_next   = alu_res.value;
                    end
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                // no carry means the position is below the expected one
                if (!alu_res.carry || too_far)
                begin
                    state_next = S_IDLE;
                end
                else if (alu_res.value == '0)
                begin
                    state_next = S_FIRST;
                end
                else
                begin
                    mem_wr_en             = 1'b1;
                    held_valid_next[slot] = 1'b1;
                    if (!held_valid_reg[slot])
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIRST, S_EMIT:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    expect_next = alu_res.value;
                    head_next   = head_inc;
                    if (state_reg == S_EMIT)
                    begin
                        held_valid_next[head_reg] = 1'b0;
                        cnt_next                  = cnt_reg - 1'b1;
                    end
                    state_next = held_valid_reg[head_inc] ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            expect_reg     <= '0;
            end_known_reg  <= 1'b0;
            end_pos_reg    <= '0;
            cnt_reg        <= '0;
            head_reg       <= '0;
            held_valid_reg <= '0;
            win_size_reg   <= bsr_pkg::WINDOW_SIZE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            expect_reg     <= expect_next;
            end_known_reg  <= end_known_next;
            end_pos_reg    <= end_pos_next;
            cnt_reg        <= cnt_next;
            head_reg       <= head_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                win_size_reg <= window_size;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        byte_reg <= byte_next;
        if (load_out)
        begin
            out_byte_reg  <= (state_reg == S_EMIT) ? rd_data_reg : byte_reg;
            out_last_reg  <= !held_valid_reg[head_inc];
            out_ended_reg <= end_known_reg && (alu_res.value >= end_pos_reg);
            out_ack_reg   <= alu_res.value;
            out_pend_reg  <= (state_reg == S_EMIT) ? bsr_pkg::PEND_W'(cnt_reg - 1'b1)
                                                   : bsr_pkg::PEND_W'(cnt_reg);
        end
    end

    // ring: one write port, one registered read port at the head slot
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            held_bytes[slot] <= byte_reg;
        end
        rd_data_reg <= held_bytes[head_reg];
    end

    assign in_stall              = (state_reg != S_IDLE);
    assign cfg_ready             = 1'b1;
    assign out_valid             = out_valid_reg;
    assign assembled_byte        = out_byte_reg;
    assign last_of_run           = out_last_reg;
    assign stream_ended          = out_ended_reg;
    assign acknowledged_position = out_ack_reg;
    assign pending_bytes         = out_pend_reg;

    // held count tracks the valid marks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(held_valid_reg)) == 32'(cnt_reg))
        else $error("held count does not match valid marks");

    // the head slot is never marked while waiting for input
    a_head_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !held_valid_reg[head_reg])
        else $error("head slot marked while idle");

    // a result that is not last of its run means draining continues
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg == S_READ || state_reg == S_EMIT))
        else $error("run ended without last flag");

    // a presented result carries the current expected position
    a_ack_current: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ack_reg == expect_reg))
        else $error("acknowledged position out of step");

endmodule
